// ===== design/ofcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcl_pkg: shared types and codes of the frame completion ledger
// Function, wait and status codes plus the history cell record.
// ----------------------------------------------------------------------------
package ofcl_pkg;

  localparam int unsigned SerialW = 32;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned ErrW    = 16;
  localparam int unsigned StatW   = 3;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned CntW    = 5;

  localparam logic [FuncW-1:0] FUNC_ACCEPT  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_PUBLISH = 3'd1;
  localparam logic [FuncW-1:0] FUNC_QUERY   = 3'd2;
  localparam logic [FuncW-1:0] FUNC_STOP    = 3'd3;
  localparam logic [FuncW-1:0] FUNC_FATAL   = 3'd4;

  localparam logic [2:0] WAIT_AVAIL   = 3'd0;
  localparam logic [2:0] WAIT_FATAL   = 3'd1;
  localparam logic [2:0] WAIT_EVICTED = 3'd2;
  localparam logic [2:0] WAIT_STOPPED = 3'd3;
  localparam logic [2:0] WAIT_NOTYET  = 3'd4;

  localparam logic [StatW-1:0] STAT_RECOVERABLE = 3'd4;
  localparam logic [StatW-1:0] STAT_PROTO_FATAL = 3'd5;
  localparam logic [StatW-1:0] STAT_DEVICE_LOST = 3'd6;
  localparam logic [StatW-1:0] STAT_STOPPED     = 3'd7;

  localparam logic [1:0] REG_MAX_PENDING = 2'd0;
  localparam logic [1:0] REG_CAPACITY    = 2'd1;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [StatW-1:0]  status;
    logic [ErrW-1:0]   err;
  } hist_t;

  typedef struct packed {
    logic [SerialW-1:0] serial;
    logic [FrameW-1:0]  frame;
  } pend_t;

endpackage

// ===== design/ofcl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcl_in_if / ofcl_out_if: word channels of the ledger
// Valid/ready channels carrying the request and the result word.
// ----------------------------------------------------------------------------
interface ofcl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] work_serial;
  logic [31:0] frame_id;
  logic [2:0]  frame_status;
  logic [15:0] error_code;
  modport source (output valid, func, work_serial, frame_id, frame_status, error_code,
                  input ready);
  modport sink (input valid, func, work_serial, frame_id, frame_status, error_code,
                output ready);
endinterface

interface ofcl_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  wait_status;
  logic [2:0]  found_status;
  logic [15:0] found_error_code;
  logic [15:0] fatal_error_code;
  logic        credit_released;
  logic [4:0]  pending_count;
  logic [4:0]  retained_count;
  modport source (output valid, accepted, wait_status, found_status, found_error_code,
                  fatal_error_code, credit_released, pending_count, retained_count,
                  input ready);
  modport sink (input valid, accepted, wait_status, found_status, found_error_code,
                fatal_error_code, credit_released, pending_count, retained_count,
                output ready);
endinterface

// ===== design/ofcl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcl_cell: one slot of a shifting queue
// Holds one entry; shifts toward the head on pop, loads on push.
// ----------------------------------------------------------------------------
module ofcl_cell #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] from_next,
  output logic [W-1:0] data
);
  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
endmodule

// ===== design/ofcl_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcl_chain: row of queue cells with fill count
// Cell 0 is the oldest entry. A pop shifts every cell toward cell 0, a push
// writes the cell just past the (post-pop) fill. Also rotates for a search.
// ----------------------------------------------------------------------------
module ofcl_chain #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         rotate,
  output logic [W-1:0] head,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  localparam int unsigned FW = $clog2(DEPTH+1);

  logic [FW-1:0] fill_r, fill_nxt, wr_pos;
  logic [W-1:0]  cell_q [DEPTH];

  assign wr_pos = pop ? fill_r - FW'(1) : fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (pop && !push) begin
      fill_nxt = fill_r - FW'(1);
    end else if (push && !pop) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [W-1:0] nb;
    logic         ld;
    logic [FW-1:0] pos;
    assign pos = FW'(g);
    if (g == DEPTH-1) begin : g_last
      // The last cell always takes cell 0 on a shift, closing the ring when the row is full.
      assign nb = cell_q[0];
    end else begin : g_mid
      assign nb = (rotate && (pos == fill_r - FW'(1))) ? cell_q[0] : cell_q[g+1];
    end
    assign ld = push && (pos == wr_pos);
    ofcl_cell #(.W(W)) u_cell (
      .clk(clk), .shift(pop || rotate), .load(ld), .load_data(push_data),
      .from_next(nb), .data(cell_q[g])
    );
  end

  assign head = cell_q[0];
  assign fill = fill_r;
endmodule

// ===== design/in_order_frame_completion_ledger_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_frame_completion_ledger_top: in-order frame completion ledger
// Tracks pending frames and a bounded outcome history built from cell rows.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_       sink       func, serial, frame id, status, error code word
//  out_      source     one result word per request word
//  cfg_      APB slave  max_pending (0x0), outcome_capacity (0x4)
//
// Accept, stop, fatal and unused requests go from the execute state straight
// to the output state. A matching publish passes through the evict state,
// which pops history entries while the row is at capacity and then pushes
// the new outcome. A query steps the scan counter through HISTORY_DEPTH
// positions, rotating the occupied history cells once around. Reset
// (synchronous rst_n) empties both rows and clears every flag. A stalled out_
// holds the result word; the next request word is taken once it drains.
// ----------------------------------------------------------------------------
module in_order_frame_completion_ledger_top #(
  parameter int unsigned PENDING_DEPTH = 16,
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ofcl_in_if.sink     in_ch,
  ofcl_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ofcl_pkg::*;

  localparam int unsigned PFW = $clog2(PENDING_DEPTH+1);
  localparam int unsigned HFW = $clog2(HISTORY_DEPTH+1);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH+1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_EVICT = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CntW-1:0] max_pend_r, cap_r;
  logic            cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pend_r <= CntW'(2);
      cap_r      <= CntW'(16);
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_MAX_PENDING[0]) begin
        max_pend_r <= cfg_pwdata[CntW-1:0];
      end else begin
        cap_r <= cfg_pwdata[CntW-1:0];
      end
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'd0) begin
      cfg_prdata[CntW-1:0] = max_pend_r;
    end else if (cfg_paddr == {REG_CAPACITY[0], 2'b00}) begin
      cfg_prdata[CntW-1:0] = cap_r;
    end
  end

  // Clamped limits, widened so comparisons against fills are exact.
  logic [8:0] pend_lim, cap_lim;
  always_comb begin
    pend_lim = (max_pend_r == '0) ? 9'd1 : 9'(max_pend_r);
    if (pend_lim > 9'(PENDING_DEPTH)) pend_lim = 9'(PENDING_DEPTH);
    cap_lim = (cap_r == '0) ? 9'd1 : 9'(cap_r);
    if (cap_lim > 9'(HISTORY_DEPTH)) cap_lim = 9'(HISTORY_DEPTH);
  end

  // Captured request word.
  logic [FuncW-1:0]   func_r;
  logic [SerialW-1:0] serial_r;
  logic [FrameW-1:0]  frame_r;
  logic [StatW-1:0]   stat_r;
  logic [ErrW-1:0]    err_r;

  // Ledger state.
  logic              ls_v_r, lf_v_r, lc_v_r, le_v_r;
  logic [31:0]       ls_r, lf_r, lc_r, le_r;
  logic              stop_r, fatal_r;
  logic [ErrW-1:0]   fcode_r;

  // Rows.
  logic       p_pop, p_push, h_pop, h_push, h_rot;
  pend_t      p_head;
  hist_t      h_head, h_new;
  logic [PFW-1:0] p_fill;
  logic [HFW-1:0] h_fill;

  ofcl_chain #(.W($bits(pend_t)), .DEPTH(PENDING_DEPTH)) u_pend (
    .clk(clk), .rst_n(rst_n), .pop(p_pop), .push(p_push),
    .push_data({serial_r, frame_r}), .rotate(1'b0), .head(p_head), .fill(p_fill)
  );
  assign h_new = '{frame: frame_r, status: stat_r, err: err_r};
  ofcl_chain #(.W($bits(hist_t)), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .rst_n(rst_n), .pop(h_pop), .push(h_push),
    .push_data(h_new), .rotate(h_rot), .head(h_head), .fill(h_fill)
  );

  // Search bookkeeping.
  logic [HCW-1:0] scan_r, scan_nxt;
  logic           hit_r, hit_nxt;
  logic [StatW-1:0] hstat_r, hstat_nxt;
  logic [ErrW-1:0]  herr_r, herr_nxt;

  // Result word register.
  logic            acc_r, acc_nxt;
  logic [2:0]      wait_r, wait_nxt;

  logic acc_ok, pub_ok;
  assign acc_ok = !stop_r && !fatal_r && (9'(p_fill) < pend_lim)
               && !(ls_v_r && serial_r <= ls_r)
               && !(lf_v_r && (frame_r <= lf_r || !lc_v_r || lc_r < lf_r));
  assign pub_ok = (p_fill != '0) && p_head.serial == serial_r && p_head.frame == frame_r;

  logic do_acc, do_pub, evict_now;
  assign evict_now = (state_r == ST_EVICT) && (9'(h_fill) >= cap_lim);

  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r;
    wait_nxt = wait_r;
    scan_nxt = scan_r;
    hit_nxt = hit_r;
    hstat_nxt = hstat_r;
    herr_nxt = herr_r;
    do_acc = 1'b0;
    do_pub = 1'b0;
    p_push = 1'b0;
    p_pop = 1'b0;
    h_push = 1'b0;
    h_pop = 1'b0;
    h_rot = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_nxt = 1'b0;
        wait_nxt = WAIT_AVAIL;
        hit_nxt = 1'b0;
        hstat_nxt = '0;
        herr_nxt = '0;
        scan_nxt = '0;
        state_nxt = ST_OUT;
        if (func_r == FUNC_ACCEPT) begin
          do_acc = acc_ok;
          p_push = acc_ok;
          acc_nxt = acc_ok;
        end else if (func_r == FUNC_PUBLISH) begin
          do_pub = pub_ok;
          p_pop = pub_ok;
          acc_nxt = pub_ok;
          if (pub_ok) state_nxt = ST_EVICT;
        end else if (func_r == FUNC_QUERY) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_EVICT: begin
        if (evict_now) begin
          h_pop = 1'b1;
        end else begin
          h_push = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (scan_r == HCW'(HISTORY_DEPTH)) begin
          state_nxt = ST_OUT;
          if (!hit_r) begin
            if (fatal_r) wait_nxt = WAIT_FATAL;
            else if (le_v_r && le_r >= frame_r) wait_nxt = WAIT_EVICTED;
            else if (stop_r) wait_nxt = WAIT_STOPPED;
            else wait_nxt = WAIT_NOTYET;
          end
        end else begin
          scan_nxt = scan_r + HCW'(1);
          // Rotate once per occupied cell so the row ends where it began.
          h_rot = (HFW'(scan_r) < h_fill);
          if (!hit_r && (HFW'(scan_r) < h_fill) && h_head.frame == frame_r) begin
            hit_nxt = 1'b1;
            hstat_nxt = h_head.status;
            herr_nxt = h_head.err;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The history row only rotates while its occupied cells form the lap,
  // so rotating through empty cells is masked by the fill check above.
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r   <= in_ch.func;
      serial_r <= in_ch.work_serial;
      frame_r  <= in_ch.frame_id;
      stat_r   <= in_ch.frame_status;
      err_r    <= in_ch.error_code;
    end
    acc_r   <= acc_nxt;
    wait_r  <= wait_nxt;
    hstat_r <= hstat_nxt;
    herr_r  <= herr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r <= '0;
      hit_r <= 1'b0;
      ls_v_r <= 1'b0; lf_v_r <= 1'b0; lc_v_r <= 1'b0; le_v_r <= 1'b0;
      ls_r <= '0; lf_r <= '0; lc_r <= '0; le_r <= '0;
      stop_r <= 1'b0; fatal_r <= 1'b0; fcode_r <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r <= scan_nxt;
      hit_r <= hit_nxt;
      if (do_acc) begin
        ls_v_r <= 1'b1; ls_r <= serial_r;
        lf_v_r <= 1'b1; lf_r <= frame_r;
      end
      if (do_pub) begin
        if (stat_r <= STAT_RECOVERABLE) begin
          lc_v_r <= 1'b1; lc_r <= frame_r;
        end
        if (stat_r == STAT_PROTO_FATAL || stat_r == STAT_DEVICE_LOST) begin
          fatal_r <= 1'b1; fcode_r <= err_r;
        end else if (stat_r == STAT_STOPPED) begin
          stop_r <= 1'b1;
        end
      end
      if (h_pop) begin
        le_v_r <= 1'b1; le_r <= h_head.frame;
      end
      if (state_r == ST_EXEC && func_r == FUNC_STOP) stop_r <= 1'b1;
      if (state_r == ST_EXEC && func_r == FUNC_FATAL) begin
        fatal_r <= 1'b1; fcode_r <= err_r;
      end
    end
  end

  assign out_ch.valid            = (state_r == ST_OUT);
  assign out_ch.accepted         = acc_r;
  assign out_ch.wait_status      = wait_r;
  assign out_ch.found_status     = hstat_r;
  assign out_ch.found_error_code = herr_r;
  assign out_ch.fatal_error_code = fcode_r;
  assign out_ch.credit_released  = lc_v_r && (lc_r >= frame_r);
  assign out_ch.pending_count    = CntW'(p_fill);
  assign out_ch.retained_count   = CntW'(h_fill);

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register lost one-hot coding");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
      9'(p_fill) <= 9'(PENDING_DEPTH))
    else $error("pending fill overran the row");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
      p_push |-> 9'(p_fill) < 9'(PENDING_DEPTH))
    else $error("pending push into full row");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_OUT && !out_ch.ready) |=> state_r == ST_OUT)
    else $error("result word dropped under stall");
endmodule
